// ===== src/first_fit_heap_allocator_macros.svh =====
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// next-cycle implication, masked during reset
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffha assertion failed");

// same-cycle implication, masked during reset
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffha assertion failed");

// next-cycle implication, also checked through reset
`define FFHA_ASSERT_NEXT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ffha assertion failed");

`endif

// ===== src/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

    localparam int HEAP_BYTES_DEF   = 32 * 1024 * 1024;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_SEGMENTS_DEF = 256;

    localparam int ADDR_W     = 64;
    localparam int REQ_SIZE_W = 26;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADREQ  = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DEC, S_RD, S_CHK, S_UPR, S_UPW, S_WTK, S_WHI, S_WLO,
        S_RDN, S_CKN, S_RDP, S_CKP, S_WMG, S_DNR, S_DNW, S_RES
    } t_state;

    typedef enum logic [2:0] {
        RD_I, RD_IP1, RD_IM1, RD_UP, RD_DN
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_INIT, WR_TAKE, WR_SPLIT_HI, WR_SPLIT_LO, WR_SHIFT, WR_MERGE_P, WR_MERGE_I
    } t_wr_sel;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    i_inc;
        logic    cap_cur;
        logic    cap_n;
        logic    cap_p;
        logic    n_clr;
        logic    p_clr;
        logic    k_up_init;
        logic    k_dec;
        logic    k_dn_init;
        logic    k_inc;
        logic    cnt_inc;
        logic    cnt_sub;
        logic    st_load;
        t_status st_val;
        logic    gflag;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic bad_req;
        logic addr_zero;
        logic base_zero;
        logic hit;
        logic split;
        logic at_end;
        logic has_next;
        logic has_prev;
        logic up_more;
        logic dn_more;
        logic p_free;
        logic n_free;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

// ===== src/ffha_if.sv =====
`default_nettype none
interface ffha_req_if;
    import ffha_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [REQ_SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0]     req_address;
    modport source (output valid, req_type, req_size, req_address, input ready);
    modport sink   (input valid, req_type, req_size, req_address, output ready);
endinterface

interface ffha_rsp_if;
    import ffha_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] grant_address;
    logic [1:0]        status;
    modport source (output valid, grant_address, status, input ready);
    modport sink   (input valid, grant_address, status, output ready);
endinterface

interface ffha_cfg_if;
    import ffha_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] heap_base;
    modport source (output valid, heap_base, input ready);
    modport sink   (input valid, heap_base, output ready);
endinterface
`default_nettype wire

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator.
// Channels: i_cfg writes heap_base (always ready, one beat per write); the user must
// write it only while idle, and the block itself does not enforce this;
// i_req carries alloc (req_type 0, req_size) or free (req_type 1, req_address) beats;
// o_rsp returns one beat per request with grant_address and status.
// The segment table lives in a single RAM, one entry read or written per cycle.
// A request is scanned one table entry at a time (read, then check) up to the hit; a
// split then shifts the entries above it up one place each (read, then write), and a
// merging free shifts them down the same way after writing the merged entry.
// One request is in flight at a time.
// Reset: synchronous, active low; afterwards the init state writes the initial
// whole-heap free segment before i_req goes ready. heap_base resets to zero.
// The result sits in an output register: a new request is accepted while it waits;
// if o_rsp is stalled when the next result is done, the block holds until the
// pending beat is taken.
`default_nettype none
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    ffha_cfg_if.sink      i_cfg,
    ffha_req_if.sink      i_req,
    ffha_rsp_if.source    o_rsp
);
    import ffha_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg.valid),
        .i_cfg_heap_base     (i_cfg.heap_base),
        .i_req_type          (i_req.req_type),
        .i_req_size          (i_req.req_size),
        .i_req_address       (i_req.req_address),
        .i_rsp_ready         (o_rsp.ready),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_rsp_valid         (o_rsp.valid),
        .o_rsp_grant_address (o_rsp.grant_address),
        .o_rsp_status        (o_rsp.status)
    );
endmodule
`default_nettype wire

// ===== src/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/ffha_ctrl.sv =====
`default_nettype none
module ffha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    input  wire ffha_pkg::t_stat i_stat,
    output logic               o_req_ready,
    output ffha_pkg::t_cmd     o_cmd
);
    import ffha_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: if (i_req_valid) n_state = S_DEC;
            S_DEC: begin
                if (!i_stat.is_free) begin
                    n_state = i_stat.bad_req ? S_RES : S_RD;
                end else if (i_stat.addr_zero || i_stat.base_zero) begin
                    n_state = S_RES;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (i_stat.hit) begin
                    if (i_stat.is_free)    n_state = S_RDN;
                    else if (i_stat.split) n_state = S_UPR;
                    else                   n_state = S_WTK;
                end else begin
                    n_state = i_stat.at_end ? S_RES : S_RD;
                end
            end
            S_UPR: n_state = i_stat.up_more ? S_UPW : S_WHI;
            S_UPW: n_state = S_UPR;
            S_WTK: n_state = S_RES;
            S_WHI: n_state = S_WLO;
            S_WLO: n_state = S_RES;
            S_RDN: n_state = i_stat.has_next ? S_CKN : S_RDP;
            S_CKN: n_state = S_RDP;
            S_RDP: n_state = i_stat.has_prev ? S_CKP : S_WMG;
            S_CKP: n_state = S_WMG;
            S_WMG: n_state = (i_stat.p_free || i_stat.n_free) ? S_DNR : S_RES;
            S_DNR: n_state = i_stat.dn_more ? S_DNW : S_RES;
            S_DNW: n_state = S_DNR;
            S_RES: if (!i_stat.out_busy) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_INIT;
            end
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            S_DEC: begin
                o_cmd.st_load = 1'b1;
                if (!i_stat.is_free)       o_cmd.st_val = ST_BADREQ;
                else if (i_stat.addr_zero) o_cmd.st_val = ST_OK;
                else                       o_cmd.st_val = ST_BADFREE;
            end
            S_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_I;
            end
            S_CHK: begin
                o_cmd.cap_cur = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_val  = ST_OK;
                    o_cmd.gflag   = !i_stat.is_free;
                    o_cmd.k_up_init = !i_stat.is_free && i_stat.split;
                end else if (i_stat.at_end) begin
                    o_cmd.st_load = 1'b1;
                    o_cmd.st_val  = i_stat.is_free ? ST_BADFREE : ST_OOM;
                end else begin
                    o_cmd.i_inc = 1'b1;
                end
            end
            S_UPR: begin
                o_cmd.rd_en  = i_stat.up_more;
                o_cmd.rd_sel = RD_UP;
            end
            S_UPW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.k_dec  = 1'b1;
            end
            S_WTK: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_TAKE;
            end
            S_WHI: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_SPLIT_HI;
                o_cmd.cnt_inc = 1'b1;
            end
            S_WLO: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SPLIT_LO;
            end
            S_RDN: begin
                o_cmd.rd_en  = i_stat.has_next;
                o_cmd.rd_sel = RD_IP1;
                o_cmd.n_clr  = !i_stat.has_next;
            end
            S_CKN: o_cmd.cap_n = 1'b1;
            S_RDP: begin
                o_cmd.rd_en  = i_stat.has_prev;
                o_cmd.rd_sel = RD_IM1;
                o_cmd.p_clr  = !i_stat.has_prev;
            end
            S_CKP: o_cmd.cap_p = 1'b1;
            S_WMG: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_sel    = i_stat.p_free ? WR_MERGE_P : WR_MERGE_I;
                o_cmd.k_dn_init = 1'b1;
            end
            S_DNR: begin
                o_cmd.rd_en   = i_stat.dn_more;
                o_cmd.rd_sel  = RD_DN;
                o_cmd.cnt_sub = !i_stat.dn_more;
            end
            S_DNW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.k_inc  = 1'b1;
            end
            S_RES: o_cmd.out_load = !i_stat.out_busy;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/ffha_dp.sv =====
`default_nettype none
module ffha_dp #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [ffha_pkg::ADDR_W-1:0]       i_cfg_heap_base,
    input  wire logic                              i_req_type,
    input  wire logic [ffha_pkg::REQ_SIZE_W-1:0]   i_req_size,
    input  wire logic [ffha_pkg::ADDR_W-1:0]       i_req_address,
    input  wire logic                              i_rsp_ready,
    input  wire ffha_pkg::t_cmd                    i_cmd,
    output ffha_pkg::t_stat                        o_stat,
    output logic                                   o_rsp_valid,
    output logic [ffha_pkg::ADDR_W-1:0]            o_rsp_grant_address,
    output logic [1:0]                             o_rsp_status
);
    import ffha_pkg::*;

    localparam int OFF_W = $clog2(HEAP_BYTES);
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int ENT_W = 2 * OFF_W + 1;
    localparam logic [OFF_W-1:0] H_OFF     = OFF_W'(HEADER_BYTES);
    localparam logic [OFF_W-1:0] INIT_SIZE = OFF_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [ADDR_W-1:0] H_ADDR   = ADDR_W'(HEADER_BYTES);

    logic [ADDR_W-1:0]     r_heap_base;
    logic                  r_type;
    logic [REQ_SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0]     r_addr;
    logic [IDX_W-1:0]      r_i;
    logic [CNT_W-1:0]      r_cnt, r_k;
    logic [1:0]            r_d;
    logic [OFF_W-1:0]      r_cur_off, r_cur_size, r_n_size, r_p_off, r_p_size;
    logic                  r_n_free, r_p_free;
    t_status               r_st;
    logic                  r_gflag;
    logic                  r_ov;
    logic [ADDR_W-1:0]     r_grant;
    t_status               r_ost;

    logic                  we, re;
    logic [IDX_W-1:0]      waddr, raddr;
    logic [ENT_W-1:0]      wdata, q;
    logic [OFF_W-1:0]      q_off, q_size;
    logic                  q_free;
    logic [ADDR_W-1:0]     need, q_size64;
    logic [CNT_W-1:0]      ip1;
    logic [CNT_W:0]        k_plus_d;
    logic [IDX_W-1:0]      k_m1, k_idx;
    logic [OFF_W-1:0]      need_off, n_add;

    ffha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    assign q_free   = q[0];
    assign q_size   = q[OFF_W:1];
    assign q_off    = q[2*OFF_W:OFF_W+1];
    assign need     = (ADDR_W'(r_size) + ADDR_W'(15)) & ~ADDR_W'(15);
    assign need_off = need[OFF_W-1:0];
    assign q_size64 = ADDR_W'(q_size);
    assign ip1      = CNT_W'(r_i) + CNT_W'(1);
    assign k_plus_d = {1'b0, r_k} + (CNT_W+1)'(r_d);
    assign k_m1     = IDX_W'(r_k - CNT_W'(1));
    assign k_idx    = r_k[IDX_W-1:0];
    assign n_add    = r_n_free ? (H_OFF + r_n_size) : '0;

    always_comb begin
        o_stat           = '0;
        o_stat.is_free   = (r_type == REQ_FREE);
        o_stat.bad_req   = (r_size == '0) || (r_heap_base == '0);
        o_stat.addr_zero = (r_addr == '0);
        o_stat.base_zero = (r_heap_base == '0);
        if (r_type == REQ_FREE) begin
            o_stat.hit = !q_free && (r_heap_base + ADDR_W'(q_off) + H_ADDR == r_addr);
        end else begin
            o_stat.hit = q_free && (q_size64 >= need);
        end
        o_stat.split    = (q_size64 >= need + H_ADDR + ADDR_W'(16)) &&
                          (r_cnt < CNT_W'(MAX_SEGMENTS));
        o_stat.at_end   = (ip1 == r_cnt);
        o_stat.has_next = (ip1 < r_cnt);
        o_stat.has_prev = (r_i != '0);
        o_stat.up_more  = (r_k > ip1);
        o_stat.dn_more  = (k_plus_d < {1'b0, r_cnt});
        o_stat.p_free   = r_p_free;
        o_stat.n_free   = r_n_free;
        o_stat.out_busy = r_ov && !i_rsp_ready;
    end

    always_comb begin
        re = i_cmd.rd_en;
        case (i_cmd.rd_sel)
            RD_I:    raddr = r_i;
            RD_IP1:  raddr = ip1[IDX_W-1:0];
            RD_IM1:  raddr = r_i - IDX_W'(1);
            RD_UP:   raddr = k_m1;
            RD_DN:   raddr = k_plus_d[IDX_W-1:0];
            default: raddr = r_i;
        endcase
    end

    always_comb begin
        we = i_cmd.wr_en;
        case (i_cmd.wr_sel)
            WR_INIT: begin
                waddr = '0;
                wdata = {{OFF_W{1'b0}}, INIT_SIZE, 1'b1};
            end
            WR_TAKE: begin
                waddr = r_i;
                wdata = {r_cur_off, r_cur_size, 1'b0};
            end
            WR_SPLIT_HI: begin
                waddr = ip1[IDX_W-1:0];
                wdata = {r_cur_off + H_OFF + need_off, r_cur_size - need_off - H_OFF, 1'b1};
            end
            WR_SPLIT_LO: begin
                waddr = r_i;
                wdata = {r_cur_off, need_off, 1'b0};
            end
            WR_SHIFT: begin
                waddr = k_idx;
                wdata = q;
            end
            WR_MERGE_P: begin
                waddr = r_i - IDX_W'(1);
                wdata = {r_p_off, r_p_size + H_OFF + r_cur_size + n_add, 1'b1};
            end
            WR_MERGE_I: begin
                waddr = r_i;
                wdata = {r_cur_off, r_cur_size + n_add, 1'b1};
            end
            default: begin
                waddr = r_i;
                wdata = q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_cnt       <= CNT_W'(1);
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_valid) r_heap_base <= i_cfg_heap_base;
            if (i_cmd.cnt_inc) r_cnt <= r_cnt + CNT_W'(1);
            if (i_cmd.cnt_sub) r_cnt <= r_cnt - CNT_W'(r_d);
            if (i_cmd.out_load)  r_ov <= 1'b1;
            else if (i_rsp_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type <= i_req_type;
            r_size <= i_req_size;
            r_addr <= i_req_address;
            r_i    <= '0;
        end
        if (i_cmd.i_inc) r_i <= r_i + IDX_W'(1);
        if (i_cmd.cap_cur) begin
            r_cur_off  <= q_off;
            r_cur_size <= q_size;
        end
        if (i_cmd.cap_n) begin
            r_n_free <= q_free;
            r_n_size <= q_size;
        end
        if (i_cmd.n_clr) r_n_free <= 1'b0;
        if (i_cmd.cap_p) begin
            r_p_free <= q_free;
            r_p_off  <= q_off;
            r_p_size <= q_size;
        end
        if (i_cmd.p_clr) r_p_free <= 1'b0;
        if (i_cmd.k_up_init) r_k <= r_cnt;
        if (i_cmd.k_dec) r_k <= r_k - CNT_W'(1);
        if (i_cmd.k_inc) r_k <= r_k + CNT_W'(1);
        if (i_cmd.k_dn_init) begin
            r_k <= r_p_free ? CNT_W'(r_i) : ip1;
            r_d <= (r_p_free && r_n_free) ? 2'd2 : 2'd1;
        end
        if (i_cmd.st_load) begin
            r_st    <= i_cmd.st_val;
            r_gflag <= i_cmd.gflag;
        end else if (i_cmd.accept) begin
            r_gflag <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_grant <= r_gflag ? (r_heap_base + ADDR_W'(r_cur_off) + H_ADDR) : '0;
            r_ost   <= r_st;
        end
    end

    assign o_rsp_valid         = r_ov;
    assign o_rsp_grant_address = r_grant;
    assign o_rsp_status        = r_ost;
endmodule
`default_nettype wire

// ===== src/ffha_checker.sv =====
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"
module ffha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [63:0] i_rsp_grant_address,
    input wire logic [1:0]  i_rsp_status
);
    import ffha_pkg::*;

    logic        rsp_stall;
    logic        rsp_fail;
    logic        req_beat;
    logic [65:0] rsp_beat;

    assign rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign rsp_fail  = i_rsp_valid && (i_rsp_status != ST_OK);
    assign req_beat  = i_req_valid && i_req_ready;
    assign rsp_beat  = {i_rsp_grant_address, i_rsp_status};

    `FFHA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, i_rsp_valid && $stable(rsp_beat))
    `FFHA_ASSERT_NOW(a_fail_no_grant, i_clk, i_rst_n, rsp_fail, i_rsp_grant_address == '0)
    `FFHA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, req_beat, !i_req_ready)
    `FFHA_ASSERT_NEXT_RST(a_reset_clears, i_clk, !i_rst_n, !i_rsp_valid && !i_req_ready)
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_grant_address (o_rsp.grant_address),
    .i_rsp_status        (o_rsp.status)
);
`default_nettype wire

// ===== tb/tb_first_fit_heap_allocator.sv =====
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned HEAP_SZ = HEAP_BYTES_DEF;
    localparam longint unsigned HDR     = HEADER_BYTES_DEF;
    localparam int              MAXSEG  = MAX_SEGMENTS_DEF;
    localparam int              QUIET_LIMIT = 20000;

    typedef struct {
        logic [ADDR_W-1:0] grant_address;
        t_status           status;
    } t_heap_result;

    class t_heap_scoreboard;
        longint unsigned base;
        longint unsigned seg_off[$];
        longint unsigned seg_size[$];
        bit              seg_free[$];
        t_heap_result    pending[$];
        int              errors;

        function void clear_table();
            seg_off = {0};
            seg_size = {HEAP_SZ - HDR};
            seg_free = {1'b1};
            base = 0;
        endfunction

        function longint unsigned payload(int i);
            return base + seg_off[i] + HDR;
        endfunction

        function void drop_entry(int i);
            seg_off.delete(i);
            seg_size.delete(i);
            seg_free.delete(i);
        endfunction

        function t_heap_result allocate(longint unsigned size);
            t_heap_result r;
            longint unsigned need;
            r.grant_address = '0;
            if (size == 0 || base == 0) begin
                r.status = ST_BADREQ;
                return r;
            end
            need = (size + 15) & ~64'd15;
            r.status = ST_OOM;
            for (int i = 0; i < seg_off.size(); i++) begin
                if (!seg_free[i] || seg_size[i] < need) continue;
                if (seg_size[i] >= need + HDR + 16 && seg_off.size() < MAXSEG) begin
                    seg_off.insert(i + 1, seg_off[i] + HDR + need);
                    seg_size.insert(i + 1, seg_size[i] - need - HDR);
                    seg_free.insert(i + 1, 1'b1);
                    seg_size[i] = need;
                end
                seg_free[i] = 1'b0;
                r.grant_address = payload(i);
                r.status = ST_OK;
                return r;
            end
            return r;
        endfunction

        function t_status release_block(longint unsigned addr);
            int i;
            if (addr == 0) return ST_OK;
            if (base == 0) return ST_BADFREE;
            for (i = 0; i < seg_off.size(); i++)
                if (payload(i) == addr && !seg_free[i]) break;
            if (i >= seg_off.size()) return ST_BADFREE;
            seg_free[i] = 1'b1;
            if (i + 1 < seg_off.size() && seg_free[i + 1]) begin
                seg_size[i] += HDR + seg_size[i + 1];
                drop_entry(i + 1);
            end
            if (i > 0 && seg_free[i - 1]) begin
                seg_size[i - 1] += HDR + seg_size[i];
                drop_entry(i);
            end
            return ST_OK;
        endfunction

        function void note_request(logic kind, logic [REQ_SIZE_W-1:0] size,
                                   logic [ADDR_W-1:0] addr);
            t_heap_result r;
            if (kind == REQ_ALLOC) begin
                r = allocate(64'(size));
            end else begin
                r.grant_address = '0;
                r.status = release_block(addr);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [ADDR_W-1:0] ga, logic [1:0] st);
            t_heap_result e;
            if (pending.size() == 0) begin
                $error("unexpected result beat ga=%h status=%0d", ga, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ga !== e.grant_address) begin
                $error("grant_address expected %h actual %h", e.grant_address, ga);
                errors++;
            end
            if (st !== e.status) begin
                $error("status expected %0d actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ffha_cfg_if cfg_ch();
    ffha_req_if req_ch();
    ffha_rsp_if rsp_ch();

    first_fit_heap_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(cfg_ch.sink), .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    t_heap_scoreboard sb = new();
    int idle_pct = 38;
    bit rsp_hold = 0;
    int quiet = 0;
    longint unsigned live[$];

    initial begin
        cfg_ch.valid = 0;
        cfg_ch.heap_base = '0;
        req_ch.valid = 0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.req_size = '0;
        req_ch.req_address = '0;
        rsp_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.grant_address, rsp_ch.status);
    end

    always @(negedge i_clk) begin
        if (rsp_hold) rsp_ch.ready <= 0;
        else rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > QUIET_LIMIT) begin
            $display("tb_first_fit_heap_allocator failed");
            $finish;
        end
    end

    task automatic write_base(longint unsigned b);
        @(negedge i_clk);
        cfg_ch.valid <= 1;
        cfg_ch.heap_base <= b;
        do @(posedge i_clk); while (!cfg_ch.ready);
        // live blocks keep their offsets, so their addresses move with the base
        foreach (live[i]) live[i] = live[i] - sb.base + b;
        sb.base = b;
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic send(logic kind, int unsigned size, logic [ADDR_W-1:0] addr);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= kind;
        req_ch.req_size <= REQ_SIZE_W'(size);
        req_ch.req_address <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(kind, REQ_SIZE_W'(size), addr);
        if (kind == REQ_ALLOC && sb.pending[$].status == ST_OK)
            live.push_back(sb.pending[$].grant_address);
        if (kind == REQ_FREE && sb.pending[$].status == ST_OK && addr != 0)
            foreach (live[i]) if (live[i] == addr) begin
                live.delete(i);
                break;
            end
    endtask

    task automatic finish_req();
        @(negedge i_clk);
        req_ch.valid <= 0;
    endtask

    task automatic drain();
        finish_req();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4 * MAXSEG + 16) @(posedge i_clk);
    endtask

    task automatic random_burst(int n);
        int pick;
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                if ($urandom_range(9) == 0)
                    send(REQ_ALLOC, $urandom, '0);
                else if ($urandom_range(19) == 0)
                    send(REQ_ALLOC, $urandom_range(1 << 22), '0);
                else
                    send(REQ_ALLOC, $urandom_range(300), {$urandom, $urandom});
            end else if (pick < 88 && live.size() != 0) begin
                a = live[$urandom_range(live.size() - 1)];
                send(REQ_FREE, $urandom, a);
            end else begin
                a = {$urandom, $urandom};
                if ($urandom_range(1)) a = sb.base + HDR + 16 * $urandom_range(64);
                send(REQ_FREE, $urandom, a);
            end
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] a;
        sb.clear_table();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send(REQ_ALLOC, 16, '0);
        send(REQ_FREE, 0, 64'h40);
        send(REQ_FREE, 0, '0);
        drain();
        write_base(64'h1000_0000);
        send(REQ_ALLOC, 0, '0);
        send(REQ_ALLOC, 1, '0);
        send(REQ_ALLOC, 17, '0);
        send(REQ_ALLOC, 32'h3FF_FFFF, '0);
        send(REQ_ALLOC, 32'h200_0000, '0);
        a = live[0];
        send(REQ_FREE, 0, a);
        send(REQ_FREE, 0, a);
        send(REQ_FREE, 0, a + 1);
        send(REQ_FREE, 0, {ADDR_W{1'b1}});
        send(REQ_ALLOC, 32'(HEAP_SZ - 2 * HDR - 64), '0);
        send(REQ_ALLOC, 8, '0);
        while (live.size() != 0) send(REQ_FREE, 0, live[0]);
        drain();

        // fill the table to force unsplit grants
        for (int k = 0; k < MAXSEG + 4; k++) send(REQ_ALLOC, 16, '0);
        send(REQ_ALLOC, 40, '0);
        drain();
        write_base(64'hFFFF_FFFF_FFFF_FF00);
        random_burst(20);
        drain();
        write_base(64'h0000_0000_8000_0000);

        // hold off the receiver while requests keep coming
        fork
            begin
                rsp_hold = 1;
                repeat (3000) @(posedge i_clk);
                rsp_hold = 0;
            end
            random_burst(40);
        join

        idle_pct = 0;
        random_burst(120);
        idle_pct = 38;
        random_burst(120);
        drain();
        write_base({$urandom, $urandom} | 64'h10);
        random_burst(120);
        drain();
        write_base(64'd0);
        random_burst(10);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_first_fit_heap_allocator passed");
        else
            $display("tb_first_fit_heap_allocator failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/ffha_pkg.sv
src/ffha_if.sv
src/ffha_ram.sv
src/ffha_ctrl.sv
src/ffha_dp.sv
src/first_fit_heap_allocator.sv
src/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
